>>> src/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CWQ_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("condition wait queue check failed");

// next-cycle implication, disabled during reset
`define CWQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("condition wait queue check failed");

`endif

>>> src/cwq_pkg.sv
// types and constants of the condition wait queue
package cwq_pkg;

    localparam int NUM_CORES_DEF = 16;
    localparam int CMD_W         = 2;
    localparam int CORE_ID_W     = 4;
    localparam int MASK_W        = 16;
    localparam int CNT_OUT_W     = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_WAIT   = 2'd0,
        CMD_SIGNAL = 2'd1,
        CMD_BCAST  = 2'd2,
        CMD_INIT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_POP,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [CORE_ID_W-1:0] core_id;
    } req_t;

    typedef struct packed {
        logic [MASK_W-1:0]    signal_mask;
        logic                 queue_empty;
        logic [CNT_OUT_W-1:0] released_count;
    } res_t;

endpackage

>>> src/cwq_ram.sv
// generic single-port-write ram with registered read
module cwq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/cwq_engine.sv
// wait list sequencer: link table walk, head and tail pointers, signal mask
module cwq_engine #(
    parameter int NUM_CORES = cwq_pkg::NUM_CORES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  cwq_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output cwq_pkg::res_t res
);

    localparam int ID_W  = $clog2(NUM_CORES);
    localparam int IW    = (ID_W > cwq_pkg::CORE_ID_W) ? ID_W : cwq_pkg::CORE_ID_W;
    localparam int CNT_W = $clog2(NUM_CORES + 1);
    localparam int CW    = (CNT_W > cwq_pkg::CNT_OUT_W) ? CNT_W : cwq_pkg::CNT_OUT_W;
    localparam int SW    = (NUM_CORES > cwq_pkg::MASK_W) ? NUM_CORES : cwq_pkg::MASK_W;

    cwq_pkg::state_t      state_reg, state_next;
    cwq_pkg::cmd_t        cmd_reg, cmd_next;
    logic [ID_W-1:0]      head_reg, head_next;
    logic [ID_W-1:0]      tail_reg, tail_next;
    logic                 nonempty_reg, nonempty_next;
    logic [NUM_CORES-1:0] sig_reg, sig_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 wr_en;
    logic [ID_W-1:0]      rd_data;
    logic [IW-1:0]        id_wide;
    logic [ID_W-1:0]      id;
    logic                 id_ok;
    logic [SW-1:0]        sig_wide;
    logic [CW-1:0]        cnt_wide;

    assign id_wide = IW'(req.core_id);
    assign id      = id_wide[ID_W-1:0];
    assign id_ok   = int'(req.core_id) < NUM_CORES;

    cwq_ram #(
        .WIDTH(ID_W),
        .DEPTH(NUM_CORES)
    ) u_link_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(tail_reg),
        .wr_data(id),
        .rd_addr(head_reg),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cwq_pkg::ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
            sig_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            sig_reg      <= sig_next;
        end
        cmd_reg <= cmd_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        sig_next      = sig_reg;
        cnt_next      = cnt_reg;
        wr_en         = 1'b0;
        req_ready     = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            cwq_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd_next   = req.cmd;
                    cnt_next   = '0;
                    state_next = cwq_pkg::ST_DONE;
                    case (req.cmd)
                        cwq_pkg::CMD_WAIT: begin
                            if (id_ok) begin
                                sig_next  = sig_reg & ~(NUM_CORES'(1) << id);
                                tail_next = id;
                                if (!nonempty_reg) begin
                                    head_next     = id;
                                    nonempty_next = 1'b1;
                                end else begin
                                    wr_en = 1'b1;
                                end
                            end
                        end
                        cwq_pkg::CMD_SIGNAL, cwq_pkg::CMD_BCAST: begin
                            if (nonempty_reg) begin
                                state_next = cwq_pkg::ST_READ;
                            end
                        end
                        cwq_pkg::CMD_INIT: begin
                            head_next     = '0;
                            tail_next     = '0;
                            nonempty_next = 1'b0;
                        end
                        default: begin
                            state_next = cwq_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            cwq_pkg::ST_READ: begin
                // link of the head core arrives next cycle
                state_next = cwq_pkg::ST_POP;
            end
            cwq_pkg::ST_POP: begin
                sig_next   = sig_reg | (NUM_CORES'(1) << head_reg);
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = cwq_pkg::ST_DONE;
                if (head_reg != tail_reg) begin
                    head_next = rd_data;
                end else begin
                    head_next     = '0;
                    tail_next     = '0;
                    nonempty_next = 1'b0;
                end
                if (cmd_reg == cwq_pkg::CMD_BCAST) begin
                    if (head_reg != tail_reg && cnt_reg < CNT_W'(NUM_CORES - 1)) begin
                        state_next = cwq_pkg::ST_READ;
                    end else begin
                        head_next     = '0;
                        tail_next     = '0;
                        nonempty_next = 1'b0;
                    end
                end
            end
            cwq_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = cwq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cwq_pkg::ST_IDLE;
            end
        endcase
    end

    assign sig_wide = SW'(sig_reg);
    assign cnt_wide = CW'(cnt_reg);

    always_comb begin
        res.signal_mask = sig_wide[cwq_pkg::MASK_W-1:0];
        res.queue_empty = !nonempty_reg;
        if (cnt_wide > CW'({cwq_pkg::CNT_OUT_W{1'b1}})) begin
            res.released_count = {cwq_pkg::CNT_OUT_W{1'b1}};
        end else begin
            res.released_count = cnt_wide[cwq_pkg::CNT_OUT_W-1:0];
        end
    end

endmodule

>>> src/condition_wait_queue.sv
// condition wait queue top level: request port, engine and result register
//
// requests arrive on s_valid/s_ready with s_cmd (wait, signal, broadcast,
// init) and s_core_id; one result per request leaves on m_valid/m_ready
// carrying the signal mask, the queue-empty flag and the released count.
// waiting cores are kept as a linked list in a link table ram; each pop
// reads that ram through its registered port, in a read state and then a
// pop state. wait and init finish without a ram read; signal releases
// at most one core and broadcast up to num_cores. one request is in the
// engine at a time; the next is taken in the cycle after the previous
// result moves to the output register, so the engine cannot take a new
// request before it has finished the last one.
// the output register holds a result while m_ready is low; the engine
// finishes its next request and then holds it until the register frees.
// synchronous reset clears the queue and the signal mask; the link table
// keeps its contents, as entries are only read after being written.
module condition_wait_queue #(
    parameter int NUM_CORES = cwq_pkg::NUM_CORES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [cwq_pkg::CMD_W-1:0]        s_cmd,
    input  logic [cwq_pkg::CORE_ID_W-1:0]    s_core_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [cwq_pkg::MASK_W-1:0]       m_signal_mask,
    output logic                             m_queue_empty,
    output logic [cwq_pkg::CNT_OUT_W-1:0]    m_released_count
);

    `include "assert_macros.svh"

    localparam int MAX_CNT = (NUM_CORES < 31) ? NUM_CORES : 31;

    cwq_pkg::req_t req;
    cwq_pkg::res_t res;
    cwq_pkg::res_t out_reg;
    logic          res_valid;
    logic          res_ready;
    logic          m_valid_reg, m_valid_next;

    assign req.cmd     = cwq_pkg::cmd_t'(s_cmd);
    assign req.core_id = s_core_id;

    cwq_engine #(
        .NUM_CORES(NUM_CORES)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_valid(s_valid),
        .req_ready(s_ready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_signal_mask    = out_reg.signal_mask;
    assign m_queue_empty    = out_reg.queue_empty;
    assign m_released_count = out_reg.released_count;

    // no new request while a finished one waits in the engine
    `CWQ_ASSERT(a_busy_while_result, aclk, aresetn, res_valid, !s_ready)
    // an accepted request keeps the engine busy next cycle
    `CWQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // never more releases than cores
    `CWQ_ASSERT(a_count_bound, aclk, aresetn, m_valid, int'(m_released_count) <= MAX_CNT)
    // only broadcast releases several cores, and it leaves the queue empty
    `CWQ_ASSERT(a_bcast_empties, aclk, aresetn, m_valid && m_released_count > 1, m_queue_empty)

endmodule
